/* rtl/mvsm_pkg.sv */
// shared types, codes and the per-voice step function of the voice mixer
`default_nettype none
package mvsm_pkg;

   // request kinds carried in tuser
   localparam logic [2:0] KIND_LOAD   = 3'd0;
   localparam logic [2:0] KIND_START  = 3'd1;
   localparam logic [2:0] KIND_VOLUME = 3'd2;
   localparam logic [2:0] KIND_STOP   = 3'd3;
   localparam logic [2:0] KIND_MIX    = 3'd4;

   // configuration register indexes
   localparam logic REG_MASTER_VOLUME = 1'b0;

   localparam logic [8:0] MASTER_VOLUME_RESET = 9'd179;

   // saturation limits of an output sample
   localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
   localparam logic signed [15:0] SAT_MIN = 16'sh8000;

   // width of one voice's contribution to a channel
   localparam int TermW = 19;

   typedef struct packed {
      logic        active;
      logic [15:0] base;
      logic [15:0] pos;
      logic [15:0] rem;
      logic [15:0] len;
      logic [15:0] loop_start;
      logic        loop_en;
      logic        eight_bit;
      logic [9:0]  left_vol;
      logic [9:0]  right_vol;
   } voice_type;

   // write command broadcast to every cell
   typedef struct packed {
      logic        start;
      logic        set_vol;
      logic        stop;
      logic [15:0] base;
      logic [15:0] len;
      logic [15:0] loop_start;
      logic        loop_en;
      logic        eight_bit;
      logic [9:0]  left_vol;
      logic [9:0]  right_vol;
   } cell_cmd_type;

   typedef struct packed {
      voice_type   next;
      logic        hit;
      logic [15:0] addr;
   } step_type;

   // one frame of one voice: end rule, fetch address, advance, end rule
   function automatic step_type voice_step(voice_type v);
      step_type r;
      voice_type t;
      t      = v;
      r.hit  = 1'b0;
      r.addr = 16'd0;
      if (v.active && (v.left_vol != 10'd0 || v.right_vol != 10'd0)) begin
         if (t.rem == 16'd0) begin
            if (t.loop_en && t.loop_start < t.len) begin
               t.pos = t.loop_start;
               t.rem = t.len - t.loop_start;
            end else begin
               t.active = 1'b0;
            end
         end
         if (t.active) begin
            r.hit  = 1'b1;
            r.addr = t.base + t.pos;
            t.pos  = t.pos + 16'd1;
            t.rem  = t.rem - 16'd1;
            if (t.rem == 16'd0) begin
               if (t.loop_en && t.loop_start < t.len) begin
                  t.pos = t.loop_start;
                  t.rem = t.len - t.loop_start;
               end else begin
                  t.active = 1'b0;
               end
            end
         end
      end
      r.next = t;
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/mvsm_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module mvsm_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   // write or read one word per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

/* rtl/mvsm_cell.sv */
// one voice cell of the rotating voice ring
`default_nettype none
module mvsm_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      shift,
   input  wire mvsm_pkg::voice_type       neighbor,
   input  wire logic                      sel,
   input  wire mvsm_pkg::cell_cmd_type    cmd,
   output mvsm_pkg::voice_type            voice
);
   mvsm_pkg::voice_type voice_ff;
   mvsm_pkg::voice_type voice_in;

   // take the neighbor's voice while rotating, else apply commands
   always_comb begin
      voice_in = voice_ff;
      if (shift) begin
         voice_in = neighbor;
      end else if (sel) begin
         if (cmd.start) begin
            voice_in.active     = 1'b1;
            voice_in.base       = cmd.base;
            voice_in.pos        = 16'd0;
            voice_in.rem        = cmd.len;
            voice_in.len        = cmd.len;
            voice_in.loop_start = cmd.loop_start;
            voice_in.loop_en    = cmd.loop_en;
            voice_in.eight_bit  = cmd.eight_bit;
            voice_in.left_vol   = cmd.left_vol;
            voice_in.right_vol  = cmd.right_vol;
         end
         if (cmd.set_vol) begin
            voice_in.left_vol  = cmd.left_vol;
            voice_in.right_vol = cmd.right_vol;
         end
         if (cmd.stop) begin
            voice_in.active = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_ff <= '0;
      end else begin
         voice_ff <= voice_in;
      end
   end

   assign voice = voice_ff;
endmodule
`default_nettype wire

/* rtl/mvsm_mix.sv */
// per-voice products, channel accumulators, master gain and saturation
`default_nettype none
module mvsm_mix #(
   parameter int AccW = 25
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clear,
   input  wire logic               fetch_valid,
   input  wire logic               fetch_hit,
   input  wire logic               fetch_eight,
   input  wire logic [9:0]         fetch_left_vol,
   input  wire logic [9:0]         fetch_right_vol,
   input  wire logic [15:0]        sample,
   input  wire logic               scale,
   input  wire logic [8:0]         master_volume,
   output logic                    busy,
   output logic signed [15:0]      left_sat,
   output logic signed [15:0]      right_sat
);
   localparam int ProdW = AccW + 10;

   logic                            term_valid_ff;
   logic signed [mvsm_pkg::TermW-1:0] term_l_ff, term_r_ff;
   logic signed [mvsm_pkg::TermW-1:0] term_l_in, term_r_in;
   logic signed [AccW-1:0]          acc_l_ff, acc_r_ff;
   logic signed [ProdW-1:0]         scaled_l_ff, scaled_r_ff;
   logic signed [ProdW-9:0]         shift_l, shift_r;
   logic signed [7:0]               s8;
   logic signed [15:0]              s16;
   logic signed [10:0]              vol_l, vol_r;
   logic signed [18:0]              p8_l, p8_r;
   logic signed [26:0]              p16_l, p16_r;

   // signed sample times unsigned volume for one voice
   always_comb begin
      s8    = sample[7:0];
      s16   = sample;
      vol_l = signed'({1'b0, fetch_left_vol});
      vol_r = signed'({1'b0, fetch_right_vol});
      p8_l  = 19'(s8) * 19'(vol_l);
      p8_r  = 19'(s8) * 19'(vol_r);
      p16_l = 27'(s16) * 27'(vol_l);
      p16_r = 27'(s16) * 27'(vol_r);
      term_l_in = '0;
      term_r_in = '0;
      if (fetch_hit) begin
         if (fetch_eight) begin
            term_l_in = p8_l;
            term_r_in = p8_r;
         end else begin
            term_l_in = mvsm_pkg::TermW'(p16_l >>> 8);
            term_r_in = mvsm_pkg::TermW'(p16_r >>> 8);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
      end else begin
         term_valid_ff <= fetch_valid;
      end
   end

   always_ff @(posedge clock) begin
      term_l_ff <= term_l_in;
      term_r_ff <= term_r_in;
   end

   // channel accumulators
   always_ff @(posedge clock) begin
      if (clear) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (term_valid_ff) begin
         acc_l_ff <= acc_l_ff + AccW'(term_l_ff);
         acc_r_ff <= acc_r_ff + AccW'(term_r_ff);
      end
   end

   // master gain
   always_ff @(posedge clock) begin
      if (scale) begin
         scaled_l_ff <= ProdW'(acc_l_ff) * ProdW'(signed'({1'b0, master_volume}));
         scaled_r_ff <= ProdW'(acc_r_ff) * ProdW'(signed'({1'b0, master_volume}));
      end
   end

   // shift down and saturate
   always_comb begin
      shift_l = scaled_l_ff[ProdW-1:8];
      shift_r = scaled_r_ff[ProdW-1:8];
      if (shift_l > ProdW'(mvsm_pkg::SAT_MAX)) begin
         left_sat = mvsm_pkg::SAT_MAX;
      end else if (shift_l < ProdW'(mvsm_pkg::SAT_MIN)) begin
         left_sat = mvsm_pkg::SAT_MIN;
      end else begin
         left_sat = shift_l[15:0];
      end
      if (shift_r > ProdW'(mvsm_pkg::SAT_MAX)) begin
         right_sat = mvsm_pkg::SAT_MAX;
      end else if (shift_r < ProdW'(mvsm_pkg::SAT_MIN)) begin
         right_sat = mvsm_pkg::SAT_MIN;
      end else begin
         right_sat = shift_r[15:0];
      end
   end

   assign busy = term_valid_ff;
endmodule
`default_nettype wire

/* rtl/multi_voice_sample_mixer.sv */
// top level of the stereo multi-voice sample mixer
// Usage: requests arrive on req_ (tuser = kind, tdata = voice fields). A load
// writes one sample word, start/volume/stop update one voice cell. A mix
// request rotates the ring of VOICES voice cells once, one voice per cycle
// past a single step unit that fetches the sample from the store and
// advances the voice; a two-stage product and accumulate pipe, a registered
// master gain stage and a saturate into the output register follow. The one
// store read port is visited once per voice of a mix.
// Only mix requests give a response on rsp_; other kinds give none.
// While a response waits on a stalled rsp_tready, further non-mix requests
// and a next mix are accepted; that mix holds its result in the gain stage
// until the output register frees.
// Reset clears all voices and sets master_volume to 179; the sample store
// is not cleared, and only words written by a load may be played.
// The user writes master_volume over the csr_ port while the block is idle;
// the block itself does not enforce this. SAMPLE_WORDS is a power of two.
`default_nettype none
module multi_voice_sample_mixer #(
   parameter int VOICES       = 32,
   parameter int SAMPLE_WORDS = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // voice[4:0] address[20:5] sample_value[36:21] sample_length[52:37]
   // loop_enable[53] loop_point[69:54] eight_bit[70] left_volume[80:71]
   // right_volume[90:81] zero[95:91]
   input  wire logic [95:0] req_tdata,
   // kind[2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // left_sample[15:0] right_sample[31:16]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int IdxW  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int AddrW = $clog2(SAMPLE_WORDS);
   localparam int AccW  = mvsm_pkg::TermW + $clog2(VOICES) + 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MIX   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [IdxW-1:0]      count_ff, count_in;
   logic                 drain_ff, drain_in;
   logic [8:0]           master_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;
   logic                 fetch_valid_ff, fetch_hit_ff, fetch_eight_ff;
   logic [9:0]           fetch_lv_ff, fetch_rv_ff;

   logic                 req_take, mix_take, load_take, mixing, mix_last;
   logic [4:0]           f_voice;
   logic [15:0]          f_address, f_sample_value, f_sample_length, f_loop_point;
   logic                 f_loop_enable, f_eight_bit;
   logic [9:0]           f_left_volume, f_right_volume;
   mvsm_pkg::cell_cmd_type cmd;
   mvsm_pkg::voice_type  voices [VOICES];
   mvsm_pkg::step_type   step;
   logic [15:0]          addr16;
   logic [AddrW-1:0]     ram_addr;
   logic [15:0]          ram_rdata;
   logic                 mix_busy;
   logic signed [15:0]   left_sat, right_sat;
   logic                 out_free, csr_write;

   // request fields
   assign f_voice         = req_tdata[4:0];
   assign f_address       = req_tdata[20:5];
   assign f_sample_value  = req_tdata[36:21];
   assign f_sample_length = req_tdata[52:37];
   assign f_loop_enable   = req_tdata[53];
   assign f_loop_point    = req_tdata[69:54];
   assign f_eight_bit     = req_tdata[70];
   assign f_left_volume   = req_tdata[80:71];
   assign f_right_volume  = req_tdata[90:81];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign mix_take   = req_take && (req_tuser == mvsm_pkg::KIND_MIX);
   assign load_take  = req_take && (req_tuser == mvsm_pkg::KIND_LOAD);
   assign mixing     = (state_ff == ST_MIX);
   assign mix_last   = mixing && (count_ff == IdxW'(VOICES - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // voice command broadcast
   always_comb begin
      cmd.start      = req_take && (req_tuser == mvsm_pkg::KIND_START);
      cmd.set_vol    = req_take && (req_tuser == mvsm_pkg::KIND_VOLUME);
      cmd.stop       = req_take && (req_tuser == mvsm_pkg::KIND_STOP);
      cmd.base       = f_address;
      cmd.len        = f_sample_length;
      cmd.loop_start = f_loop_point;
      cmd.loop_en    = f_loop_enable;
      cmd.eight_bit  = f_eight_bit;
      cmd.left_vol   = f_left_volume;
      cmd.right_vol  = f_right_volume;
   end

   // step unit works on the head cell
   assign step = mvsm_pkg::voice_step(voices[0]);

   // ring of voice cells, head steps into the tail
   for (genvar i = 0; i < VOICES; i++) begin : g_cell
      mvsm_pkg::voice_type nb;
      if (i == VOICES - 1) begin : g_tail
         assign nb = step.next;
      end else begin : g_body
         assign nb = voices[i + 1];
      end
      mvsm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (mixing),
         .neighbor (nb),
         .sel      (32'(f_voice) == i),
         .cmd      (cmd),
         .voice    (voices[i])
      );
   end

   // store address, cut or zero-extended to the store size
   assign addr16 = mixing ? step.addr : f_address;
   if (AddrW <= 16) begin : g_addr_narrow
      assign ram_addr = addr16[AddrW-1:0];
   end else begin : g_addr_wide
      assign ram_addr = {{(AddrW - 16){1'b0}}, addr16};
   end

   mvsm_ram #(
      .Width (16),
      .Depth (SAMPLE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (load_take),
      .addr  (ram_addr),
      .wdata (f_sample_value),
      .rdata (ram_rdata)
   );

   // fetch metadata aligned with the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_valid_ff <= 1'b0;
      end else begin
         fetch_valid_ff <= mixing;
      end
   end

   always_ff @(posedge clock) begin
      fetch_hit_ff   <= step.hit;
      fetch_eight_ff <= voices[0].eight_bit;
      fetch_lv_ff    <= voices[0].left_vol;
      fetch_rv_ff    <= voices[0].right_vol;
   end

   mvsm_mix #(
      .AccW (AccW)
   ) u_mix (
      .clock           (clock),
      .reset           (reset),
      .clear           (mix_take),
      .fetch_valid     (fetch_valid_ff),
      .fetch_hit       (fetch_hit_ff),
      .fetch_eight     (fetch_eight_ff),
      .fetch_left_vol  (fetch_lv_ff),
      .fetch_right_vol (fetch_rv_ff),
      .sample          (ram_rdata),
      .scale           (state_ff == ST_SCALE),
      .master_volume   (master_ff),
      .busy            (mix_busy),
      .left_sat        (left_sat),
      .right_sat       (right_sat)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drain_in = drain_ff;
      unique case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (mix_take) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            count_in = count_ff + IdxW'(1);
            if (mix_last) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drain_ff <= drain_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {right_sat, left_sat};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == {mvsm_pkg::REG_MASTER_VOLUME, 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= mvsm_pkg::MASTER_VOLUME_RESET;
      end else if (csr_write) begin
         master_ff <= csr_pwdata[8:0];
      end
   end

   assign csr_prdata = (csr_paddr == {mvsm_pkg::REG_MASTER_VOLUME, 2'b00})
                       ? {23'd0, master_ff} : 32'd0;

`ifndef NO_ASSERTIONS
   // store is never written during a frame
   a_no_load_in_mix: assert property (@(posedge clock) disable iff (reset)
      load_take |-> state_ff == ST_IDLE)
      else $error("store written outside idle");

   // accumulator only runs while a frame is in flight
   a_acc_in_frame: assert property (@(posedge clock) disable iff (reset)
      mix_busy |-> (state_ff == ST_MIX || state_ff == ST_DRAIN))
      else $error("accumulate outside frame");

   // a response appears only after the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response without frame");

   // the ring stops rotating after the last voice of a frame
   a_ring_count: assert property (@(posedge clock) disable iff (reset)
      mix_last |=> state_ff == ST_DRAIN)
      else $error("ring rotation miscounted");
`endif
endmodule
`default_nettype wire

/* verif/multi_voice_sample_mixer_tb.sv */
// self-checking testbench for the stereo multi-voice sample mixer
`timescale 1ns / 100ps
`default_nettype none
module multi_voice_sample_mixer_tb;

   localparam int NUM_VOICES = 32;
   localparam int IDLE_LIMIT = 20000;
   localparam int MIX_CYCLES = 40;
   localparam int SEED_WORDS = 48;
   localparam int RANDOM_PER_PHASE = 56;
   localparam logic [2:0] CSR_ADDR_MASTER_VOLUME = 3'd0;

   // one request as the block sees it
   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  voice;
      logic [15:0] address;
      logic [15:0] sample_value;
      logic [15:0] sample_length;
      logic        loop_enable;
      logic [15:0] loop_point;
      logic        eight_bit;
      logic [9:0]  left_volume;
      logic [9:0]  right_volume;
   } request_type;

   // directed row: request plus optional typed-in frame
   typedef struct {
      request_type req;
      logic        has_frame;
      logic [15:0] left;
      logic [15:0] right;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   multi_voice_sample_mixer u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [15:0]          store_mem [int];
   mvsm_pkg::voice_type  voices [NUM_VOICES];
   logic [8:0]           gain;
   logic [31:0]          frames_due [$];

   int errors = 0;
   int mixes_checked = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit recv_hold = 1'b0;

   function automatic logic signed [63:0] floor_shr8(logic signed [63:0] x);
      return x >>> 8;
   endfunction

   function automatic logic [15:0] clamp16(logic signed [63:0] x);
      if (x > 64'sd32767) return 16'h7fff;
      if (x < -64'sd32768) return 16'h8000;
      return x[15:0];
   endfunction

   // end of sound: reload a valid loop, else stop
   function automatic mvsm_pkg::voice_type wrap_voice(mvsm_pkg::voice_type v);
      if (v.rem == 16'd0) begin
         if (v.loop_en && v.loop_start < v.len) begin
            v.pos = v.loop_start;
            v.rem = v.len - v.loop_start;
         end else begin
            v.active = 1'b0;
         end
      end
      return v;
   endfunction

   // apply one request, push the frame a mix produces
   task automatic apply_request(request_type r);
      logic signed [63:0] sum_l, sum_r, s;
      logic [15:0] w, a;
      mvsm_pkg::voice_type v;
      sum_l = 0;
      sum_r = 0;
      case (r.kind)
         mvsm_pkg::KIND_LOAD: store_mem[r.address] = r.sample_value;
         mvsm_pkg::KIND_START: begin
            v.active = 1'b1;
            v.base = r.address;
            v.pos = 16'd0;
            v.rem = r.sample_length;
            v.len = r.sample_length;
            v.loop_start = r.loop_point;
            v.loop_en = r.loop_enable;
            v.eight_bit = r.eight_bit;
            v.left_vol = r.left_volume;
            v.right_vol = r.right_volume;
            voices[r.voice] = v;
         end
         mvsm_pkg::KIND_VOLUME: begin
            voices[r.voice].left_vol = r.left_volume;
            voices[r.voice].right_vol = r.right_volume;
         end
         mvsm_pkg::KIND_STOP: voices[r.voice].active = 1'b0;
         mvsm_pkg::KIND_MIX: begin
            for (int i = 0; i < NUM_VOICES; i++) begin
               v = voices[i];
               if (!v.active || (v.left_vol == 0 && v.right_vol == 0)) continue;
               v = wrap_voice(v);
               if (v.active && v.rem != 0) begin
                  a = v.base + v.pos;
                  w = store_mem.exists(a) ? store_mem[a] : 16'd0;
                  if (v.eight_bit) begin
                     s = 64'($signed(w[7:0]));
                     sum_l += s * $signed({1'b0, v.left_vol});
                     sum_r += s * $signed({1'b0, v.right_vol});
                  end else begin
                     s = 64'($signed(w));
                     sum_l += floor_shr8(s * $signed({1'b0, v.left_vol}));
                     sum_r += floor_shr8(s * $signed({1'b0, v.right_vol}));
                  end
                  v.pos = v.pos + 16'd1;
                  v.rem = v.rem - 16'd1;
                  v = wrap_voice(v);
               end
               voices[i] = v;
            end
            frames_due.push_back({clamp16(floor_shr8(sum_r * $signed({1'b0, gain}))),
                                  clamp16(floor_shr8(sum_l * $signed({1'b0, gain})))});
         end
         default: ;
      endcase
   endtask

   function automatic logic [95:0] pack_fields(request_type r);
      return {5'd0, r.right_volume, r.left_volume, r.eight_bit, r.loop_point,
              r.loop_enable, r.sample_length, r.sample_value, r.address, r.voice};
   endfunction

   // send one request, predicting at acceptance
   task automatic send_request(request_type r);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_fields(r);
      req_tuser <= r.kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(r);
      @(negedge clock);
   endtask

   // stop sending, wait until nothing is outstanding, then let the pipe drain
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (frames_due.size() != 0) @(negedge clock);
      repeat (MIX_CYCLES) @(negedge clock);
   endtask

   task automatic write_gain(logic [8:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_MASTER_VOLUME;
      csr_pwdata <= {23'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      gain = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // random request; a start stays inside the words seeded for the region
   task automatic random_request(output request_type r, input int region);
      int pick;
      int off;
      r = '0;
      r.voice = 5'($urandom());
      r.left_volume = ($urandom_range(9, 0) == 0) ? 10'd0 : 10'($urandom());
      r.right_volume = ($urandom_range(9, 0) == 0) ? 10'd0 : 10'($urandom());
      if ($urandom_range(19, 0) == 0) r.right_volume = 10'h3ff;
      pick = int'($urandom_range(99, 0));
      if (pick < 25) begin
         r.kind = mvsm_pkg::KIND_LOAD;
         r.address = 16'((region << 8) + int'($urandom_range(255, 0)));
         if ($urandom_range(15, 0) == 0) r.address = 16'($urandom());
         r.sample_value = 16'($urandom());
      end else if (pick < 40) begin
         r.kind = mvsm_pkg::KIND_START;
         off = int'($urandom_range(7, 0));
         r.address = 16'((region << 8) + off);
         r.sample_length = 16'($urandom_range(40, 0));
         if ($urandom_range(30, 0) == 0) r.sample_length = 16'hffff;
         // never play past the seeded words
         if (int'(r.sample_length) > SEED_WORDS - off)
            r.sample_length = 16'(SEED_WORDS - off);
         r.loop_enable = 1'($urandom());
         r.loop_point = 16'($urandom_range(45, 0));
         if ($urandom_range(20, 0) == 0) r.loop_point = 16'($urandom());
         r.eight_bit = 1'($urandom());
      end else if (pick < 48) begin
         r.kind = mvsm_pkg::KIND_VOLUME;
      end else if (pick < 53) begin
         r.kind = mvsm_pkg::KIND_STOP;
      end else if (pick < 56) begin
         r.kind = 3'($urandom_range(7, 5));
         r.address = 16'($urandom());
         r.sample_value = 16'($urandom());
         r.sample_length = 16'($urandom());
         r.loop_point = 16'($urandom());
         r.loop_enable = 1'($urandom());
         r.eight_bit = 1'($urandom());
      end else begin
         r.kind = mvsm_pkg::KIND_MIX;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frames_due.size() == 0) begin
            $error("unexpected frame %h", rsp_tdata);
            errors++;
         end else begin
            want = frames_due.pop_front();
            if (rsp_tdata[15:0] !== want[15:0]) begin
               $error("left_sample expected %h actual %h", want[15:0], rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[31:16] !== want[31:16]) begin
               $error("right_sample expected %h actual %h", want[31:16], rsp_tdata[31:16]);
               errors++;
            end
            mixes_checked++;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (recv_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("multi_voice_sample_mixer: mismatch");
         $finish;
      end
   end

   // directed table and random phases
   initial begin
      row_type rows [$];
      row_type row;
      request_type r;
      int region;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = mvsm_pkg::KIND_LOAD;
      rsp_tready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gain = mvsm_pkg::MASTER_VOLUME_RESET;
      foreach (voices[i]) voices[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset all voices are silent
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_MIX; row.has_frame = 1'b1;
      rows.push_back(row);
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_LOAD; row.req.address = 16'd0;
      row.req.sample_value = 16'h7fff; rows.push_back(row);
      row.req.address = 16'd1; row.req.sample_value = 16'h8000; rows.push_back(row);
      row.req.address = 16'hffff; row.req.sample_value = 16'h0080; rows.push_back(row);
      row.req.address = 16'd2; row.req.sample_value = 16'hff7f; rows.push_back(row);
      // 16-bit voice looping over full-scale words
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_START; row.req.voice = 5'd31;
      row.req.address = 16'd0; row.req.sample_length = 16'd2; row.req.loop_enable = 1'b1;
      row.req.left_volume = 10'h3ff; row.req.right_volume = 10'h3ff; rows.push_back(row);
      // 8-bit voice with base wrapping past the top of the store
      row.req.voice = 5'd0; row.req.address = 16'hffff; row.req.sample_length = 16'd3;
      row.req.eight_bit = 1'b1; row.req.loop_point = 16'd1; row.req.left_volume = 10'd0;
      rows.push_back(row);
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_MIX;
      repeat (4) rows.push_back(row);
      // volumes to zero leaves a voice frozen
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_VOLUME; row.req.voice = 5'd31;
      rows.push_back(row);
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_MIX; rows.push_back(row);
      // loop start at length stops the voice
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_START; row.req.voice = 5'd5;
      row.req.sample_length = 16'd1; row.req.loop_enable = 1'b1; row.req.loop_point = 16'd1;
      row.req.left_volume = 10'd1; rows.push_back(row);
      // zero-length start
      row.req.voice = 5'd6; row.req.sample_length = 16'd0; row.req.loop_point = 16'd0;
      rows.push_back(row);
      row = '{default: '0}; row.req.kind = mvsm_pkg::KIND_MIX; repeat (2) rows.push_back(row);
      // unused kinds and stop
      row = '{default: '1}; row.req.kind = 3'd7; row.has_frame = 1'b0; rows.push_back(row);
      row = '{default: '0}; row.req.kind = 3'd5; rows.push_back(row);
      row.req.kind = mvsm_pkg::KIND_STOP; row.req.voice = 5'd0; rows.push_back(row);
      row.req.voice = 5'd31; rows.push_back(row);
      row.req.kind = mvsm_pkg::KIND_MIX; row.has_frame = 1'b1; rows.push_back(row);

      foreach (rows[i]) begin
         send_request(rows[i].req);
         if (rows[i].has_frame && frames_due.size() != 0)
            frames_due[$] = {rows[i].right, rows[i].left};
      end
      drain_results();

      // random phases over several gain settings and idling mixes
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         case (phase)
            0: write_gain(9'd256);
            1: write_gain(9'd0);
            2: write_gain(9'h1ff);
            3: write_gain(9'd1);
            default: write_gain(9'($urandom()));
         endcase
         region = int'($urandom_range(255, 0));
         // seed the words that starts in this region may play
         for (int k = 0; k < SEED_WORDS; k++) begin
            r = '0; r.kind = mvsm_pkg::KIND_LOAD; r.address = 16'((region << 8) + k);
            r.sample_value = 16'($urandom());
            send_request(r);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            random_request(r, region);
            send_request(r);
            // long receiver hold-off while the sender keeps going
            if (phase == 0 && n == 50) begin
               recv_hold = 1'b1;
               fork
                  begin repeat (400) @(negedge clock); recv_hold = 1'b0; end
               join_none
            end
            // sender pause until every frame is back
            if (phase == 1 && n == 50) drain_results();
         end
         drain_results();
      end

      $display("covered %0d checked frames over directed rows and random phases,", mixes_checked);
      $display("with four gain extremes, stalls on both sides and a long output hold");
      if (errors == 0 && frames_due.size() == 0) begin
         $display("multi_voice_sample_mixer: match");
      end else begin
         $display("multi_voice_sample_mixer: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
rtl/mvsm_pkg.sv
rtl/mvsm_ram.sv
rtl/mvsm_cell.sv
rtl/mvsm_mix.sv
rtl/multi_voice_sample_mixer.sv
verif/multi_voice_sample_mixer_tb.sv
